[hw/rtl/row_fir_pkg.sv]
// Shared constants and types of the row FIR convolution block.
package row_fir_pkg;

   localparam int MAX_TAPS_DEF        = 7;
   localparam int SAMPLE_BITS_DEF     = 16;
   localparam int COEFF_FRAC_BITS_DEF = 14;

   localparam int COEFF_BITS      = 16;
   localparam int NUM_COEFFS      = 7;
   localparam int TAP_COUNT_BITS  = 3;
   localparam int TAP_CLAMP_BITS  = 4;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 3'd3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TAP_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEFF_BASE = 3'd1;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [COEFF_BITS-1:0] coeff_reset(input int idx);
      logic [COEFF_BITS-1:0] val;
      val = '0;
      if (idx == 1) begin
         val = 16'h4000;
      end
      return val;
   endfunction

endpackage

[hw/rtl/row_fir_queue.sv]
// Short word queue between the front and back of the row FIR.
module row_fir_queue
   import row_fir_pkg::*;
#(
   parameter int WIDTH = 113
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] store [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == CW'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
      pop_data = store[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/row_fir_front.sv]
// Front end: pixel window, row tracking and row-end flush; issues filter jobs.
module row_fir_front
   import row_fir_pkg::*;
#(
   parameter int MAX_TAPS    = MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int CW = $clog2(MAX_TAPS + 1),
   localparam int WW = MAX_TAPS * SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   input  logic                   row_last,
   input  logic [CW-1:0]          taps,
   input  queue_status_type       status,
   output logic                   push,
   output logic [WW-1:0]          job_window,
   output logic                   job_last
);

   logic [WW-1:0]          window_ff, window_in;
   logic [CW-1:0]          seen_ff, seen_in;
   logic [CW-1:0]          step_ff, step_in;
   logic                   flush_ff, flush_in;
   logic [CW-1:0]          half;
   logic [SAMPLE_BITS-1:0] shift_val;
   logic [WW-1:0]          win_shift;
   logic                   accept;
   logic                   flush_step;

   always_comb begin
      half       = taps >> 1;
      shift_val  = flush_ff ? '0 : in_sample;
      win_shift  = '0;
      win_shift[SAMPLE_BITS-1:0] = shift_val;
      for (int i = 1; i < MAX_TAPS; i++) begin
         win_shift[i*SAMPLE_BITS +: SAMPLE_BITS] = window_ff[(i-1)*SAMPLE_BITS +: SAMPLE_BITS];
      end
      req_tready = !flush_ff && !status.full;
      accept     = req_tvalid && req_tready;
      flush_step = flush_ff && !status.full;

      window_in  = window_ff;
      seen_in    = seen_ff;
      step_in    = step_ff;
      flush_in   = flush_ff;
      push       = 1'b0;
      job_last   = 1'b0;
      job_window = win_shift;

      if (accept) begin
         window_in = win_shift;
         push      = (seen_ff >= half);
         if (!row_last) begin
            if (seen_ff != CW'(MAX_TAPS)) begin
               seen_in = CW'(seen_ff + 1'b1);
            end
         end else if (half == '0) begin
            job_last  = 1'b1;
            window_in = '0;
            seen_in   = '0;
         end else begin
            flush_in = 1'b1;
            step_in  = CW'(1);
         end
      end else if (flush_step) begin
         window_in = win_shift;
         push      = ({1'b0, seen_ff} + {1'b0, step_ff}) >= {1'b0, half};
         if (step_ff == half) begin
            job_last  = 1'b1;
            window_in = '0;
            seen_in   = '0;
            flush_in  = 1'b0;
         end else begin
            step_in = CW'(step_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= '0;
         step_ff   <= '0;
         flush_ff  <= 1'b0;
      end else begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
         step_ff   <= step_in;
         flush_ff  <= flush_in;
      end
   end

endmodule

[hw/rtl/row_fir_back.sv]
// Back end: multiply, two-level sum, floor shift and saturation, output register.
module row_fir_back
   import row_fir_pkg::*;
#(
   parameter int MAX_TAPS        = MAX_TAPS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
   localparam int WW = MAX_TAPS * SAMPLE_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  queue_status_type           status,
   output logic                       pop,
   input  logic [WW-1:0]              job_window,
   input  logic                       job_last,
   input  logic [MAX_TAPS*COEFF_BITS-1:0] coeffs,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [SAMPLE_BITS-1:0]     out_sample,
   output logic                       out_last
);

   localparam int PW   = SAMPLE_BITS + COEFF_BITS;
   localparam int SW   = PW + $clog2(MAX_TAPS + 1);
   localparam int HALF = (MAX_TAPS + 1) / 2;

   logic signed [PW-1:0] prod_ff [MAX_TAPS];
   logic signed [SW-1:0] lo_ff, hi_ff, lo_in, hi_in;
   logic signed [SW-1:0] total_ff;
   logic signed [SW-1:0] shifted;
   logic [SW-SAMPLE_BITS:0] upper;
   logic [SAMPLE_BITS-1:0] sat;
   logic [SAMPLE_BITS-1:0] out_sample_ff;
   logic v1_ff, v2_ff, v3_ff, rsp_tvalid_ff;
   logic l1_ff, l2_ff, l3_ff, out_last_ff;
   logic advance;

   always_comb begin
      advance = !rsp_tvalid_ff || rsp_tready;
      pop     = advance && !status.empty;
      lo_in   = '0;
      hi_in   = '0;
      for (int t = 0; t < MAX_TAPS; t++) begin
         if (t < HALF) begin
            lo_in = lo_in + SW'(prod_ff[t]);
         end else begin
            hi_in = hi_in + SW'(prod_ff[t]);
         end
      end
      shifted = total_ff >>> COEFF_FRAC_BITS;
      upper   = shifted[SW-1:SAMPLE_BITS-1];
      if ((&upper) || !(|upper)) begin
         sat = shifted[SAMPLE_BITS-1:0];
      end else if (shifted[SW-1]) begin
         sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff         <= !status.empty;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         rsp_tvalid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int t = 0; t < MAX_TAPS; t++) begin
            prod_ff[t] <= $signed(job_window[t*SAMPLE_BITS +: SAMPLE_BITS])
                        * $signed(coeffs[t*COEFF_BITS +: COEFF_BITS]);
         end
         l1_ff         <= job_last;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         l2_ff         <= l1_ff;
         total_ff      <= lo_ff + hi_ff;
         l3_ff         <= l2_ff;
         out_sample_ff <= sat;
         out_last_ff   <= l3_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign out_sample = out_sample_ff;
   assign out_last   = out_last_ff;

endmodule

[hw/rtl/row_fir_convolution.sv]
// Top level of the row FIR convolution: control registers, front, queue and back.
//
// Zero-padded 1-D convolution of an image row with an odd kernel of up to MAX_TAPS
// taps (Q1.14 coefficients), floor shift by COEFF_FRAC_BITS and saturation to the
// sample width. One pixel word is taken per cycle while the queue has room; result
// words come out a fixed four-stage pipeline (product, half sums, total, saturate)
// behind a four-word job queue. Outputs lag the input by h = (taps-1)/2 pixels; at
// the row's last pixel the front stops taking words while it shifts zeros through
// the window to flush the remaining h outputs. tlast marks the last pixel of a row
// on input and the last output of the row on the result side. Configuration words
// are taken every cycle and should be written only while no word is in flight.
module row_fir_convolution
   import row_fir_pkg::*;
#(
   parameter int MAX_TAPS        = MAX_TAPS_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
   localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [DW-1:0]             req_tdata,   // in_sample
   input  logic                      req_tlast,   // row_last
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [DW-1:0]             rsp_tdata,   // out_sample
   output logic                      rsp_tlast,   // out_last
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COEFF_BITS-1:0]     csr_data
);

   localparam int CW = $clog2(MAX_TAPS + 1);
   localparam int WW = MAX_TAPS * SAMPLE_BITS;
   localparam int JW = WW + 1;

   logic [TAP_COUNT_BITS-1:0] tap_count_ff;
   logic [COEFF_BITS-1:0]     coeff_ff [NUM_COEFFS];
   logic [TAP_CLAMP_BITS-1:0] t_raw, t_clamp, t_odd;
   logic [CW-1:0]             taps;
   logic [MAX_TAPS*COEFF_BITS-1:0] coeffs;
   logic [CSR_INDEX_BITS-1:0] coeff_sel;

   queue_status_type status;
   logic             push, pop;
   logic [WW-1:0]    front_window;
   logic             front_last;
   logic [JW-1:0]    q_out;
   logic [SAMPLE_BITS-1:0] out_sample;

   assign csr_ready = 1'b1;
   assign coeff_sel = CSR_INDEX_BITS'(csr_index - REG_COEFF_BASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
         for (int i = 0; i < NUM_COEFFS; i++) begin
            coeff_ff[i] <= coeff_reset(i);
         end
      end else if (csr_valid) begin
         if (csr_index == REG_TAP_COUNT) begin
            tap_count_ff <= csr_data[TAP_COUNT_BITS-1:0];
         end else begin
            coeff_ff[coeff_sel] <= csr_data;
         end
      end
   end

   always_comb begin
      t_raw   = {1'b0, tap_count_ff};
      t_clamp = (t_raw > TAP_CLAMP_BITS'(MAX_TAPS)) ? TAP_CLAMP_BITS'(MAX_TAPS) : t_raw;
      t_odd   = t_clamp;
      if (!t_clamp[0]) begin
         t_odd = (t_clamp == '0) ? TAP_CLAMP_BITS'(1) : TAP_CLAMP_BITS'(t_clamp - 1'b1);
      end
      taps = t_odd[CW-1:0];
   end

   for (genvar t = 0; t < MAX_TAPS; t++) begin : g_coeff
      if (t < NUM_COEFFS) begin : g_used
         assign coeffs[t*COEFF_BITS +: COEFF_BITS] =
            (t < int'(taps)) ? coeff_ff[t] : '0;
      end else begin : g_zero
         assign coeffs[t*COEFF_BITS +: COEFF_BITS] = '0;
      end
   end

   row_fir_front #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .in_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .row_last   (req_tlast),
      .taps       (taps),
      .status     (status),
      .push       (push),
      .job_window (front_window),
      .job_last   (front_last)
   );

   row_fir_queue #(
      .WIDTH (JW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({front_last, front_window}),
      .pop       (pop),
      .pop_data  (q_out),
      .status    (status)
   );

   row_fir_back #(
      .MAX_TAPS        (MAX_TAPS),
      .SAMPLE_BITS     (SAMPLE_BITS),
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .pop        (pop),
      .job_window (q_out[WW-1:0]),
      .job_last   (q_out[WW]),
      .coeffs     (coeffs),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_sample (out_sample),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = DW'(out_sample);

endmodule
